[rtl/dmr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dmr_pkg;

  localparam int MAX_BITS_DEF = 32;
  localparam int FRAME_W      = 32;
  localparam int COUNT_W      = 6;
  localparam int TMO_W        = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;

  // receiver state codes as seen on state_code
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_START    = 3'd1;
  localparam logic [2:0] ST_RLOW     = 3'd2;
  localparam logic [2:0] ST_RHIGH    = 3'd3;
  localparam logic [2:0] ST_HALF     = 3'd4;
  localparam logic [2:0] ST_BITSTART = 3'd5;

  localparam logic [1:0] PC_INVALID = 2'd0;
  localparam logic [1:0] PC_SHORT   = 2'd1;
  localparam logic [1:0] PC_LONG    = 2'd2;
  localparam logic [1:0] PC_TIMEOUT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd2;

  localparam logic [10:0] HALF_BIT_RST  = 11'd416;
  localparam logic [11:0] BIT_RST       = 12'd833;
  localparam logic [7:0]  TOLERANCE_RST = 8'd20;

  typedef struct packed {
    logic [10:0] half_bit_us;
    logic [11:0] bit_us;
    logic [7:0]  tolerance_us;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         state_code;
    logic [TMO_W-1:0]   timeout_us;
    logic               timeout_off;
    logic               rearm_timer;
    logic               frame_done;
    logic [FRAME_W-1:0] frame_data;
    logic [COUNT_W-1:0] frame_bits;
    logic               release_bus;
    logic [1:0]         pulse_class;
  } res_t;

  // timer value armed on entry to a state
  function automatic logic [TMO_W-1:0] state_timeout(input logic [2:0] st,
                                                     input logic [10:0] half_bit,
                                                     input logic [11:0] bit_w);
    logic [13:0] h3;
    logic [13:0] b3;
    logic [TMO_W-1:0] tmo;
    h3 = {3'b000, half_bit} + {2'b00, half_bit, 1'b0};
    b3 = {2'b00, bit_w} + {1'b0, bit_w, 1'b0};
    case (st)
      ST_START:    tmo = h3[13:1];
      ST_HALF:     tmo = b3[13:1];
      ST_RLOW,
      ST_RHIGH,
      ST_BITSTART: tmo = {bit_w, 1'b0};
      default:     tmo = '0;
    endcase
    return tmo;
  endfunction

endpackage

`default_nettype wire

[rtl/dmr_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface dmr_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] pulse_width_us;
  logic        line_level;

  modport source (output valid, output req_type, output pulse_width_us,
                  output line_level, input ready);
  modport sink   (input valid, input req_type, input pulse_width_us,
                  input line_level, output ready);
endinterface

interface dmr_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   state_code;
  logic [dmr_pkg::TMO_W-1:0]    timeout_us;
  logic                         timeout_off;
  logic                         rearm_timer;
  logic                         frame_done;
  logic [dmr_pkg::FRAME_W-1:0]  frame_data;
  logic [dmr_pkg::COUNT_W-1:0]  frame_bits;
  logic                         release_bus;
  logic [1:0]                   pulse_class;

  modport source (output valid, output state_code, output timeout_us,
                  output timeout_off, output rearm_timer, output frame_done,
                  output frame_data, output frame_bits, output release_bus,
                  output pulse_class, input ready);
  modport sink   (input valid, input state_code, input timeout_us,
                  input timeout_off, input rearm_timer, input frame_done,
                  input frame_data, input frame_bits, input release_bus,
                  input pulse_class, output ready);
endinterface

interface dmr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dmr_pkg::CFG_IDX_W-1:0]   index;
  logic [dmr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/dmr_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module dmr_cfg_regs (
  input  wire logic           clk,
  input  wire logic           rst_n,
  dmr_cfg_if.sink             cfg_chan,
  output dmr_pkg::cfg_t       cfg
);

  dmr_pkg::cfg_t cfg_r;
  dmr_pkg::cfg_t cfg_nxt;

  assign cfg_chan.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        dmr_pkg::CFG_HALF_BIT:  cfg_nxt.half_bit_us  = cfg_chan.data[10:0];
        dmr_pkg::CFG_BIT:       cfg_nxt.bit_us       = cfg_chan.data[11:0];
        dmr_pkg::CFG_TOLERANCE: cfg_nxt.tolerance_us = cfg_chan.data[7:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_bit_us  <= dmr_pkg::HALF_BIT_RST;
      cfg_r.bit_us       <= dmr_pkg::BIT_RST;
      cfg_r.tolerance_us <= dmr_pkg::TOLERANCE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/dmr_classify.sv]
`timescale 1ns / 1ps
`default_nettype none

module dmr_classify (
  input  wire logic          req_type,
  input  wire logic [15:0]   pulse_width_us,
  input  wire dmr_pkg::cfg_t cfg,
  output logic [1:0]         pulse_class
);

  // signed compares; a negative lower bound admits zero width
  logic signed [17:0] w_s;
  logic signed [17:0] h_lo;
  logic signed [17:0] h_hi;
  logic signed [17:0] b_lo;
  logic signed [17:0] b_hi;

  assign w_s  = $signed({2'b00, pulse_width_us});
  assign h_lo = $signed({7'd0, cfg.half_bit_us}) - $signed({10'd0, cfg.tolerance_us});
  assign h_hi = $signed({7'd0, cfg.half_bit_us}) + $signed({10'd0, cfg.tolerance_us});
  assign b_lo = $signed({6'd0, cfg.bit_us}) - $signed({10'd0, cfg.tolerance_us});
  assign b_hi = $signed({6'd0, cfg.bit_us}) + $signed({10'd0, cfg.tolerance_us});

  always_comb begin
    if (req_type) begin
      pulse_class = dmr_pkg::PC_TIMEOUT;
    end else if (w_s < h_lo) begin
      pulse_class = dmr_pkg::PC_INVALID;
    end else if (w_s < h_hi) begin
      pulse_class = dmr_pkg::PC_SHORT;
    end else if (w_s < b_lo) begin
      pulse_class = dmr_pkg::PC_INVALID;
    end else if (w_s < b_hi) begin
      pulse_class = dmr_pkg::PC_LONG;
    end else begin
      pulse_class = dmr_pkg::PC_INVALID;
    end
  end

endmodule

`default_nettype wire

[rtl/dmr_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none

module dmr_decoder #(
  parameter int MAX_BITS = dmr_pkg::MAX_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire logic          line_level,
  input  wire logic [1:0]    pulse_class,
  input  wire dmr_pkg::cfg_t cfg,
  output dmr_pkg::res_t      res
);

  localparam int CNT_LIM = (MAX_BITS < dmr_pkg::FRAME_W) ? MAX_BITS : dmr_pkg::FRAME_W;
  localparam logic [dmr_pkg::FRAME_W-1:0] SHIFT_MASK =
    (CNT_LIM >= dmr_pkg::FRAME_W) ? {dmr_pkg::FRAME_W{1'b1}}
                                  : dmr_pkg::FRAME_W'((64'd1 << CNT_LIM) - 64'd1);
  localparam logic [dmr_pkg::COUNT_W-1:0] COUNT_MAX = dmr_pkg::COUNT_W'(CNT_LIM);

  typedef enum logic [2:0] {
    S_IDLE     = dmr_pkg::ST_IDLE,
    S_START    = dmr_pkg::ST_START,
    S_RLOW     = dmr_pkg::ST_RLOW,
    S_RHIGH    = dmr_pkg::ST_RHIGH,
    S_HALF     = dmr_pkg::ST_HALF,
    S_BITSTART = dmr_pkg::ST_BITSTART
  } rx_state_t;

  rx_state_t                      rx_state_r, rx_state_nxt;
  rx_state_t                      reset_st;
  logic [dmr_pkg::FRAME_W-1:0]    shift_r, shift_nxt;
  logic [dmr_pkg::COUNT_W-1:0]    count_r, count_nxt;
  logic                           last_bit_r, last_bit_nxt;
  logic                           finish;
  logic                           release_req;
  logic                           push;
  logic                           push_val;

  always_comb begin
    reset_st     = line_level ? S_RHIGH : S_RLOW;
    rx_state_nxt = rx_state_r;
    shift_nxt    = shift_r;
    count_nxt    = count_r;
    last_bit_nxt = last_bit_r;
    finish       = 1'b0;
    release_req  = 1'b0;
    push         = 1'b0;
    push_val     = last_bit_r;

    case (rx_state_r)
      S_IDLE: begin
        if (pulse_class != dmr_pkg::PC_TIMEOUT) rx_state_nxt = S_START;
      end
      S_START: begin
        if (pulse_class == dmr_pkg::PC_SHORT) begin
          last_bit_nxt = 1'b1;
          shift_nxt    = '0;
          count_nxt    = '0;
          rx_state_nxt = S_HALF;
        end else begin
          rx_state_nxt = S_RHIGH;
        end
      end
      S_RLOW: begin
        rx_state_nxt = (pulse_class == dmr_pkg::PC_TIMEOUT) ? S_IDLE : reset_st;
      end
      S_RHIGH: begin
        if (pulse_class == dmr_pkg::PC_TIMEOUT) begin
          release_req  = 1'b1;
          rx_state_nxt = reset_st;
        end else begin
          rx_state_nxt = S_RLOW;
        end
      end
      S_HALF: begin
        if (pulse_class == dmr_pkg::PC_SHORT) begin
          rx_state_nxt = S_BITSTART;
        end else if (pulse_class == dmr_pkg::PC_LONG) begin
          // long pulse in mid-bit: the bit value flips
          last_bit_nxt = ~last_bit_r;
          push         = 1'b1;
          push_val     = ~last_bit_r;
          rx_state_nxt = S_HALF;
        end else if (pulse_class == dmr_pkg::PC_TIMEOUT && last_bit_r) begin
          finish = 1'b1;
        end else begin
          rx_state_nxt = reset_st;
        end
      end
      S_BITSTART: begin
        if (pulse_class == dmr_pkg::PC_SHORT) begin
          push         = 1'b1;
          rx_state_nxt = S_HALF;
        end else if (pulse_class == dmr_pkg::PC_TIMEOUT && !last_bit_r) begin
          finish = 1'b1;
        end else begin
          rx_state_nxt = reset_st;
        end
      end
      default: begin
        rx_state_nxt = reset_st;
      end
    endcase

    if (push) begin
      shift_nxt = {shift_r[dmr_pkg::FRAME_W-2:0], push_val} & SHIFT_MASK;
      // count saturates, the oldest bits fall off the top
      if (count_r < COUNT_MAX) count_nxt = count_r + 1'b1;
    end

    if (finish) begin
      shift_nxt    = '0;
      count_nxt    = '0;
      rx_state_nxt = S_IDLE;
    end
  end

  always_comb begin
    res.state_code  = rx_state_nxt;
    res.timeout_us  = dmr_pkg::state_timeout(rx_state_nxt, cfg.half_bit_us, cfg.bit_us);
    res.timeout_off = (rx_state_nxt == S_IDLE);
    res.rearm_timer = (rx_state_nxt != rx_state_r);
    res.frame_done  = finish;
    res.frame_data  = finish ? shift_r : '0;
    res.frame_bits  = finish ? count_r : '0;
    res.release_bus = release_req;
    res.pulse_class = pulse_class;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_state_r <= S_RLOW;
      shift_r    <= '0;
      count_r    <= '0;
      last_bit_r <= 1'b0;
    end else if (fire) begin
      rx_state_r <= rx_state_nxt;
      shift_r    <= shift_nxt;
      count_r    <= count_nxt;
      last_bit_r <= last_bit_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/dali_manchester_receiver.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake      payload
// in_chan   in   valid/ready    req_type, pulse_width_us, line_level
// out_chan  out  valid/ready    state_code ... pulse_class (one result per request)
// cfg_chan  in   valid/ready    index, data (ready always high)
//
// a request passes the input register, then is decoded into the result register
// one request per cycle sustained while out_chan.ready is high; the decoder state
// updates as a request moves into the result register
// a stalled result holds the result register; the input register still takes
// one more request, then in_chan.ready drops until out_chan.ready returns
// rst_n is synchronous; state returns to resetting low, timing registers and valid flags to defaults

module dali_manchester_receiver #(
  parameter int MAX_BITS = dmr_pkg::MAX_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dmr_in_if.sink      in_chan,
  dmr_out_if.source   out_chan,
  dmr_cfg_if.sink     cfg_chan
);

  logic           s1_valid_r, s1_valid_nxt;
  logic           s1_req_type_r;
  logic [15:0]    s1_width_r;
  logic           s1_level_r;
  logic           out_valid_r, out_valid_nxt;
  dmr_pkg::res_t  out_r;
  dmr_pkg::res_t  res;
  dmr_pkg::cfg_t  cfg;
  logic [1:0]     pulse_class;
  logic           advance;
  logic           s1_fire;
  logic           in_acc;

  assign advance       = !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && advance;
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_acc        = in_chan.valid && in_chan.ready;

  dmr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  dmr_classify u_classify (
    .req_type       (s1_req_type_r),
    .pulse_width_us (s1_width_r),
    .cfg            (cfg),
    .pulse_class    (pulse_class)
  );

  dmr_decoder #(
    .MAX_BITS (MAX_BITS)
  ) u_decoder (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_fire),
    .line_level  (s1_level_r),
    .pulse_class (pulse_class),
    .cfg         (cfg),
    .res         (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_type_r <= in_chan.req_type;
      s1_width_r    <= in_chan.pulse_width_us;
      s1_level_r    <= in_chan.line_level;
    end
    if (s1_fire) begin
      out_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.state_code  = out_r.state_code;
  assign out_chan.timeout_us  = out_r.timeout_us;
  assign out_chan.timeout_off = out_r.timeout_off;
  assign out_chan.rearm_timer = out_r.rearm_timer;
  assign out_chan.frame_done  = out_r.frame_done;
  assign out_chan.frame_data  = out_r.frame_data;
  assign out_chan.frame_bits  = out_r.frame_bits;
  assign out_chan.release_bus = out_r.release_bus;
  assign out_chan.pulse_class = out_r.pulse_class;

`ifndef SYNTH
  // a finished frame always leaves the receiver idle with the timer off
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.frame_done |->
      out_r.state_code == dmr_pkg::ST_IDLE && out_r.timeout_off)
    else $error("frame done without idle state");

  a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.frame_done |->
      out_r.frame_data == '0 && out_r.frame_bits == '0)
    else $error("frame fields set without frame done");

  a_release_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.release_bus |->
      out_r.pulse_class == dmr_pkg::PC_TIMEOUT && out_r.rearm_timer == 1'b0 ||
      out_valid_r && out_r.release_bus && out_r.pulse_class == dmr_pkg::PC_TIMEOUT)
    else $error("bus release without timeout");

  // a request taken always lands in the input register
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted request lost");
`endif

endmodule

`default_nettype wire

[sim/dmr_checker.sv]
`timescale 1ns / 1ps

module dmr_checker #(
  parameter int MAX_BITS = dmr_pkg::MAX_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  dmr_in_if    in_mon,
  dmr_out_if   out_mon,
  dmr_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);
  import dmr_pkg::*;

  localparam int BIT_LIMIT = (MAX_BITS < 32) ? MAX_BITS : 32;

  // mirror of the timing registers
  logic [10:0] half_bit;
  logic [11:0] bit_w;
  logic [7:0]  tol;

  // mirror of the decoder
  logic [2:0]         rx_state;
  logic [FRAME_W-1:0] shift_reg;
  logic [COUNT_W-1:0] nbits;
  logic               lb;

  res_t rx_results[$];
  res_t want;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (fail_count < 200)
      $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, exp_val);
    fail_count++;
  endtask

  function automatic logic [1:0] pulse_kind(input logic [15:0] w);
    int wi, h, b, t;
    wi = w;
    h = half_bit;
    b = bit_w;
    t = tol;
    if (wi < h - t) return PC_INVALID;
    if (wi < h + t) return PC_SHORT;
    if (wi < b - t) return PC_INVALID;
    if (wi < b + t) return PC_LONG;
    return PC_INVALID;
  endfunction

  function automatic logic [TMO_W-1:0] arm_value(input logic [2:0] st);
    int v;
    case (st)
      ST_START:    v = int'(half_bit) * 3 / 2;
      ST_HALF:     v = int'(bit_w) * 3 / 2;
      ST_RLOW,
      ST_RHIGH,
      ST_BITSTART: v = int'(bit_w) * 2;
      default:     v = 0;
    endcase
    return TMO_W'(v);
  endfunction

  function automatic void shift_in(input logic b);
    shift_reg = {shift_reg[FRAME_W-2:0], b};
    if (BIT_LIMIT < 32)
      shift_reg = shift_reg & ((32'd1 << BIT_LIMIT) - 32'd1);
    if (nbits < BIT_LIMIT) nbits++;
  endfunction

  function automatic res_t decode_event(input logic typ, input logic [15:0] w,
                                        input logic lvl);
    res_t r;
    logic [1:0] kind;
    logic [2:0] fallback, nxt;
    logic rel, fin;
    kind = typ ? PC_TIMEOUT : pulse_kind(w);
    fallback = lvl ? ST_RHIGH : ST_RLOW;
    nxt = rx_state;
    rel = 1'b0;
    fin = 1'b0;
    r = '0;
    case (rx_state)
      ST_IDLE: begin
        // idle has no timer, a stray timeout changes nothing
        if (kind != PC_TIMEOUT) nxt = ST_START;
      end
      ST_START: begin
        if (kind == PC_SHORT) begin
          lb = 1'b1;
          shift_reg = '0;
          nbits = '0;
          nxt = ST_HALF;
        end else begin
          nxt = ST_RHIGH;
        end
      end
      ST_RLOW: nxt = (kind == PC_TIMEOUT) ? ST_IDLE : fallback;
      ST_RHIGH: begin
        if (kind == PC_TIMEOUT) begin
          rel = 1'b1;
          nxt = fallback;
        end else begin
          nxt = ST_RLOW;
        end
      end
      ST_HALF: begin
        if (kind == PC_SHORT) begin
          nxt = ST_BITSTART;
        end else if (kind == PC_LONG) begin
          lb = ~lb;
          shift_in(lb);
        end else if (kind == PC_TIMEOUT && lb) begin
          fin = 1'b1;
        end else begin
          nxt = fallback;
        end
      end
      ST_BITSTART: begin
        if (kind == PC_SHORT) begin
          shift_in(lb);
          nxt = ST_HALF;
        end else if (kind == PC_TIMEOUT && !lb) begin
          fin = 1'b1;
        end else begin
          nxt = fallback;
        end
      end
      default: nxt = fallback;
    endcase
    if (fin) begin
      r.frame_done = 1'b1;
      r.frame_data = shift_reg;
      r.frame_bits = nbits;
      shift_reg = '0;
      nbits = '0;
      nxt = ST_IDLE;
    end
    r.state_code = nxt;
    r.timeout_us = arm_value(nxt);
    r.timeout_off = (nxt == ST_IDLE);
    r.rearm_timer = (nxt != rx_state);
    r.release_bus = rel;
    r.pulse_class = kind;
    rx_state = nxt;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      half_bit = HALF_BIT_RST;
      bit_w = BIT_RST;
      tol = TOLERANCE_RST;
      rx_state = ST_RLOW;
      shift_reg = '0;
      nbits = '0;
      lb = 1'b0;
      rx_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (rx_results.size() == 0) begin
          report_mismatch("unexpected result", {29'd0, out_mon.state_code}, 32'd0);
        end else begin
          want = rx_results.pop_front();
          if (out_mon.state_code !== want.state_code)
            report_mismatch("state_code", out_mon.state_code, want.state_code);
          if (out_mon.timeout_us !== want.timeout_us)
            report_mismatch("timeout_us", out_mon.timeout_us, want.timeout_us);
          if (out_mon.timeout_off !== want.timeout_off)
            report_mismatch("timeout_off", out_mon.timeout_off, want.timeout_off);
          if (out_mon.rearm_timer !== want.rearm_timer)
            report_mismatch("rearm_timer", out_mon.rearm_timer, want.rearm_timer);
          if (out_mon.frame_done !== want.frame_done)
            report_mismatch("frame_done", out_mon.frame_done, want.frame_done);
          if (out_mon.frame_data !== want.frame_data)
            report_mismatch("frame_data", out_mon.frame_data, want.frame_data);
          if (out_mon.frame_bits !== want.frame_bits)
            report_mismatch("frame_bits", out_mon.frame_bits, want.frame_bits);
          if (out_mon.release_bus !== want.release_bus)
            report_mismatch("release_bus", out_mon.release_bus, want.release_bus);
          if (out_mon.pulse_class !== want.pulse_class)
            report_mismatch("pulse_class", out_mon.pulse_class, want.pulse_class);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_HALF_BIT:  half_bit = cfg_mon.data[10:0];
          CFG_BIT:       bit_w = cfg_mon.data[11:0];
          CFG_TOLERANCE: tol = cfg_mon.data[7:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        rx_results.push_back(decode_event(in_mon.req_type, in_mon.pulse_width_us,
                                          in_mon.line_level));
    end
    pending = rx_results.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import dmr_pkg::*;

  localparam logic REQ_EDGE    = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;
  localparam int   STALL_LIMIT = 2000;
  localparam int   LONG_HOLD   = 200;

  logic clk = 1'b0;
  logic rst_n;

  dmr_in_if  in_if ();
  dmr_out_if out_if ();
  dmr_cfg_if cfg_if ();

  int fail_count;
  int pending;

  // current timing setup, used to aim pulse widths
  int cur_h, cur_b, cur_t;
  bit src_idle, snk_idle, long_hold;
  int items_sent;
  int idle_cycles;
  int h, b, t;

  dali_manchester_receiver dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  dmr_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int hold;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        hold = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        hold = snk_idle ? $urandom_range(0, 19) : 0;
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  task automatic send_req(input logic typ, input logic [15:0] width, input logic lvl);
    int gap;
    gap = src_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= typ;
    in_if.pulse_width_us <= width;
    in_if.line_level <= lvl;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic line_edge(input int width, input logic lvl);
    send_req(REQ_EDGE, 16'(width), lvl);
  endtask

  task automatic tmo_req(input logic lvl);
    send_req(REQ_TIMEOUT, 16'($urandom), lvl);
  endtask

  // edge with a width inside the short or long window of the current setup, if that window is not empty
  task automatic nominal_edge(input logic [1:0] kind);
    int lo, hi;
    if (kind == PC_SHORT) begin
      lo = cur_h - cur_t;
      hi = cur_h + cur_t - 1;
    end else begin
      lo = cur_b - cur_t;
      hi = cur_b + cur_t - 1;
    end
    if (lo < 0) lo = 0;
    if (hi < lo) hi = lo;
    line_edge($urandom_range(hi, lo), 1'($urandom));
  endtask

  // three timeouts at low level reach idle from any state
  task automatic send_frame(input int n);
    logic lb;
    repeat (3) tmo_req(1'b0);
    line_edge($urandom_range(65535, 0), 1'($urandom));
    nominal_edge(PC_SHORT);
    lb = 1'b1;
    for (int k = 0; k < n; k++) begin
      // now and then a stray request breaks the frame
      if ($urandom_range(0, 39) == 0)
        send_req(1'($urandom), 16'($urandom), 1'($urandom));
      if ($urandom_range(0, 1)) begin
        nominal_edge(PC_LONG);
        lb = ~lb;
      end else begin
        nominal_edge(PC_SHORT);
        nominal_edge(PC_SHORT);
      end
    end
    if (!lb) nominal_edge(PC_SHORT);
    tmo_req(1'($urandom));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic run_phase(input int hb, input int bb, input int tb, input int count,
                           input bit si, input bit ki);
    int target;
    logic [15:0] w;
    cfg_write(CFG_HALF_BIT, hb);
    cfg_write(CFG_BIT, bb);
    cfg_write(CFG_TOLERANCE, tb);
    cfg_if.valid <= 1'b0;
    cur_h = hb;
    cur_b = bb;
    cur_t = tb;
    src_idle = si;
    snk_idle = ki;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1)) w = 16'($urandom);
          else w = 16'($urandom_range(2 * cur_b + 64, 0));
          send_req(1'($urandom), w, 1'($urandom));
        end
      end else if ($urandom_range(0, 9) == 0) begin
        send_frame($urandom_range(45, 33));
      end else begin
        send_frame($urandom_range(32, 0));
      end
    end
    drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.req_type <= REQ_EDGE;
    in_if.pulse_width_us <= '0;
    in_if.line_level <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_HALF_BIT;
    cfg_if.data <= '0;
    idle_cycles <= 0;
    items_sent = 0;
    long_hold = 1'b0;
    src_idle = 1'b1;
    snk_idle = 1'b1;
    cur_h = HALF_BIT_RST;
    cur_b = BIT_RST;
    cur_t = TOLERANCE_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed, at reset timing
    tmo_req(1'b0);            // resetting low to idle
    tmo_req(1'b1);            // ignored in idle
    line_edge(0, 1'b0);
    line_edge(396, 1'b0);     // lowest short, start bit
    line_edge(833, 1'b1);
    line_edge(435, 1'b0);     // highest short
    line_edge(416, 1'b1);
    line_edge(852, 1'b0);     // highest long
    line_edge(813, 1'b1);     // lowest long
    line_edge(420, 1'b0);
    tmo_req(1'b0);            // frame end from bit start
    line_edge(65535, 1'b1);
    line_edge(416, 1'b1);
    line_edge(65535, 1'b1);   // bad pulse mid frame
    tmo_req(1'b1);            // bus release
    tmo_req(1'b0);
    line_edge(853, 1'b1);
    line_edge(395, 1'b0);
    tmo_req(1'b0);
    line_edge(436, 1'b1);
    line_edge(812, 1'b0);     // start bit not short
    line_edge(0, 1'b0);
    tmo_req(1'b0);
    line_edge(1000, 1'b0);
    line_edge(416, 1'b0);
    line_edge(416, 1'b0);
    line_edge(416, 1'b0);
    tmo_req(1'b0);            // frame end from half bit
    drain();

    run_phase(HALF_BIT_RST, BIT_RST, TOLERANCE_RST, 250, 1'b1, 1'b1);
    h = $urandom_range(1800, 40);
    b = (2 * h > 4095) ? 4095 : 2 * h;
    t = $urandom_range(h / 4 + 1, 1);
    run_phase(h, b, (t > 255) ? 255 : t, 150, 1'b0, 1'b0);
    run_phase(2047, 4095, 255, 150, 1'b1, 1'b1);
    // sender flat out while the result side holds off
    long_hold = 1'b1;
    h = $urandom_range(600, 40);
    run_phase(h, 2 * h, $urandom_range(h / 4 + 1, 1), 200, 1'b0, 1'b1);
    run_phase(0, 0, 0, 60, 1'b1, 1'b0);
    run_phase(1, 2, 255, 80, 1'b1, 1'b1);
    h = $urandom_range(1800, 40);
    b = (2 * h > 4095) ? 4095 : 2 * h;
    t = $urandom_range(h / 4 + 1, 1);
    run_phase(h, b, (t > 255) ? 255 : t, 260, 1'b1, 1'b1);

    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
rtl/dmr_pkg.sv
rtl/dmr_ifs.sv
rtl/dmr_cfg_regs.sv
rtl/dmr_classify.sv
rtl/dmr_decoder.sv
rtl/dali_manchester_receiver.sv
sim/dmr_checker.sv
sim/tb_top.sv
